// ----- hdl/cst_pkg.sv -----
// Shared types, constants and helpers of the cubic segment trajectory sampler.
// Used by the channel interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps

package cst_pkg;

  // Fixed field widths
  localparam int POS_W     = 32;
  localparam int STEP_W    = 16;
  localparam int N_W       = 6;
  localparam int STEP_LIMIT = 63;
  localparam logic [STEP_W-1:0] STEP_TIME_RESET = 16'd6554;

  // Internal widths: coefficients, accumulator, serial multiplier operand, divisor
  localparam int COEF_W = 58;
  localparam int ACC_W  = 88;
  localparam int MUL_W  = 25;
  localparam int DIV_W  = 50;
  localparam int DCNT_W = 7;

  // Cycles allowed for the coefficient and step-product registers to settle
  localparam int SETTLE_CYC = 4;
  localparam int WAIT_W     = 3;

  // Accumulated terms, in evaluation order
  typedef enum logic [3:0] {
    TERM_POS_P0,
    TERM_POS_C1,
    TERM_POS_C2,
    TERM_POS_C3,
    TERM_VEL_C1,
    TERM_VEL_C2,
    TERM_VEL_C3,
    TERM_ACC_C2,
    TERM_ACC_C3
  } term_t;

  // Result fields that go through the divider
  typedef enum logic [1:0] {
    FLD_POS,
    FLD_VEL,
    FLD_ACC
  } field_t;

  // Controller to datapath commands
  typedef struct packed {
    logic   seg_ready;
    logic   k_inc;
    logic   mac_start;
    logic   clear_acc;
    term_t  term;
    logic   div_start;
    logic   store;
    field_t field;
    logic   emit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic seg_valid;
    logic mac_busy;
    logic div_busy;
    logic out_free;
    logic last_k;
  } stat_t;

  // First term of a field clears the accumulator
  function automatic logic term_first(input term_t t);
    logic r;
    case (t)
      TERM_POS_P0, TERM_VEL_C1, TERM_ACC_C2: r = 1'b1;
      default:                               r = 1'b0;
    endcase
    return r;
  endfunction

  // Last term of a field hands the sum to the divider
  function automatic logic term_last(input term_t t);
    logic r;
    case (t)
      TERM_POS_C3, TERM_VEL_C3, TERM_ACC_C3: r = 1'b1;
      default:                               r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/cst_if.sv -----
// Valid/ready channel interfaces: segment requests, sample results, step time writes.
// Depends on cst_pkg for field widths.
`timescale 1ns / 1ps

interface cst_seg_if;
  logic                              valid;
  logic                              ready;
  logic signed [cst_pkg::POS_W-1:0]  start_position;
  logic signed [cst_pkg::POS_W-1:0]  end_position;
  logic signed [cst_pkg::POS_W-1:0]  start_velocity;
  logic signed [cst_pkg::POS_W-1:0]  end_velocity;
  logic        [cst_pkg::N_W-1:0]    segment_steps;

  modport source (output valid, start_position, end_position, start_velocity,
                  end_velocity, segment_steps, input ready);
  modport sink (input valid, start_position, end_position, start_velocity,
                end_velocity, segment_steps, output ready);
endinterface

interface cst_smp_if;
  logic                              valid;
  logic                              ready;
  logic signed [cst_pkg::POS_W-1:0]  position;
  logic signed [cst_pkg::POS_W-1:0]  velocity;
  logic signed [cst_pkg::POS_W-1:0]  acceleration;
  logic        [cst_pkg::N_W-1:0]    sample_index;
  logic                              last;

  modport source (output valid, position, velocity, acceleration, sample_index, last,
                  input ready);
  modport sink (input valid, position, velocity, acceleration, sample_index, last,
                output ready);
endinterface

interface cst_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [cst_pkg::STEP_W-1:0]        step_time;

  modport source (output valid, step_time, input ready);
  modport sink (input valid, step_time, output ready);
endinterface

// ----- hdl/cubic_segment_trajectory_sampler_unit.sv -----
// Top level of the cubic segment trajectory sampler: controller plus datapath.
// Depends on cst_pkg, the channel interfaces, cst_ctrl and cst_datapath.
//
//   channel | dir | payload                                              | request
//   seg     | in  | start/end position, start/end velocity, segment_steps | one segment
//   smp     | out | position, velocity, acceleration, sample_index, last | one sample
//   cfg     | in  | step_time                                            | one write
//
// A segment of n steps gives n+1 samples (n of zero is taken as one). Each sample passes
// through a settle wait, nine multiply-accumulate terms, three restoring divisions
// of 88 quotient bits each with their store, and an emit state.
// Reset is synchronous. A stalled sample output holds the controller in its emit
// state, with the next sample in the field registers, until taken; a new segment
// is taken only after the last sample has gone into the output register.
`timescale 1ns / 1ps

module cubic_segment_trajectory_sampler_unit (
  input  logic       clk,
  input  logic       rst,
  cst_seg_if.sink    seg,
  cst_smp_if.source  smp,
  cst_cfg_if.sink    cfg
);

  cst_pkg::cmd_t  cmd;
  cst_pkg::stat_t stat;

  cst_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  cst_datapath u_datapath (
    .clk  (clk),
    .rst  (rst),
    .seg  (seg),
    .smp  (smp),
    .cfg  (cfg),
    .cmd  (cmd),
    .stat (stat)
  );

endmodule

// ----- hdl/cst_ctrl.sv -----
// Sequencing controller: walks each sample through the terms, divisions and output.
// Depends on cst_pkg for command, status, term and field types.
`timescale 1ns / 1ps

module cst_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  cst_pkg::stat_t  stat,
  output cst_pkg::cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETTLE,
    S_MAC_GO,
    S_MAC_WAIT,
    S_DIV_GO,
    S_DIV_WAIT,
    S_STORE,
    S_EMIT
  } state_t;

  state_t                        state;
  logic [cst_pkg::WAIT_W-1:0]    wait_cnt;
  cst_pkg::term_t                term;
  cst_pkg::field_t               field;

  // Hold state, settle count, current term and field
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      wait_cnt <= '0;
      term     <= cst_pkg::TERM_POS_P0;
      field    <= cst_pkg::FLD_POS;
    end else begin
      case (state)
        S_IDLE: begin
          if (stat.seg_valid) begin
            state    <= S_SETTLE;
            wait_cnt <= cst_pkg::WAIT_W'(cst_pkg::SETTLE_CYC);
          end
        end
        S_SETTLE: begin
          if (wait_cnt == '0) begin
            state <= S_MAC_GO;
            term  <= cst_pkg::TERM_POS_P0;
            field <= cst_pkg::FLD_POS;
          end else begin
            wait_cnt <= wait_cnt - 1'b1;
          end
        end
        S_MAC_GO: begin
          state <= S_MAC_WAIT;
        end
        S_MAC_WAIT: begin
          if (!stat.mac_busy) begin
            if (cst_pkg::term_last(term)) begin
              state <= S_DIV_GO;
            end else begin
              term  <= cst_pkg::term_t'(term + 1'b1);
              state <= S_MAC_GO;
            end
          end
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (!stat.div_busy) begin
            state <= S_STORE;
          end
        end
        S_STORE: begin
          case (field)
            cst_pkg::FLD_POS: begin
              field <= cst_pkg::FLD_VEL;
              term  <= cst_pkg::term_t'(term + 1'b1);
              state <= S_MAC_GO;
            end
            cst_pkg::FLD_VEL: begin
              field <= cst_pkg::FLD_ACC;
              term  <= cst_pkg::term_t'(term + 1'b1);
              state <= S_MAC_GO;
            end
            default: begin
              state <= S_EMIT;
            end
          endcase
        end
        S_EMIT: begin
          if (stat.out_free) begin
            if (stat.last_k) begin
              state <= S_IDLE;
            end else begin
              state    <= S_SETTLE;
              wait_cnt <= cst_pkg::WAIT_W'(cst_pkg::SETTLE_CYC);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Decode commands from state
  always_comb begin
    cmd           = '0;
    cmd.term      = term;
    cmd.field     = field;
    cmd.seg_ready = (state == S_IDLE);
    cmd.mac_start = (state == S_MAC_GO);
    cmd.clear_acc = (state == S_MAC_GO) && cst_pkg::term_first(term);
    cmd.div_start = (state == S_DIV_GO);
    cmd.store     = (state == S_STORE);
    cmd.emit      = (state == S_EMIT) && stat.out_free;
    cmd.k_inc     = (state == S_EMIT) && stat.out_free && !stat.last_k;
  end

endmodule

// ----- hdl/cst_datapath.sv -----
// Datapath: coefficient setup, bit-serial multiply-accumulate, restoring divider,
// rounding and saturation, step time register and output register. Uses cst_pkg.
`timescale 1ns / 1ps

module cst_datapath (
  input  logic           clk,
  input  logic           rst,
  cst_seg_if.sink        seg,
  cst_smp_if.source      smp,
  cst_cfg_if.sink        cfg,
  input  cst_pkg::cmd_t  cmd,
  output cst_pkg::stat_t stat
);

  localparam int P = cst_pkg::POS_W;
  localparam int C = cst_pkg::COEF_W;
  localparam int A = cst_pkg::ACC_W;
  localparam int M = cst_pkg::MUL_W;
  localparam int D = cst_pkg::DIV_W;

  logic [cst_pkg::STEP_W-1:0] step_time;

  // Captured request
  logic signed [P-1:0]          p0, p1, v0, v1;
  logic [cst_pkg::N_W-1:0]      n;
  logic [cst_pkg::STEP_W-1:0]   st;
  logic [cst_pkg::N_W-1:0]      k;
  logic                         load;
  logic [cst_pkg::N_W-1:0]      n_in;

  // Coefficient pipeline
  logic signed [47:0]           c1, w1;
  logic signed [48:0]           dd;
  logic [11:0]                  nn;
  logic [31:0]                  sq;
  logic signed [50:0]           s2;
  logic signed [49:0]           t2;
  logic [17:0]                  n3;
  logic signed [C-1:0]          c2, c3;
  logic [D-1:0]                 d0, d1, d2;

  // Step products
  logic [11:0]                  kk;
  logic [17:0]                  kkk, kkn;
  logic [23:0]                  kn3;
  logic [12:0]                  k2n;
  logic [13:0]                  k3;
  logic [8:0]                   k6;

  // Multiply-accumulate
  logic signed [C-1:0]          a_sel;
  logic [M-1:0]                 m_sel;
  logic signed [A-1:0]          a_reg, acc;
  logic [M-1:0]                 m_reg;

  // Divider
  logic [D-1:0]                 dv_sel, dv, rem;
  logic [A-1:0]                 mag;
  logic                         neg;
  logic [cst_pkg::DCNT_W-1:0]   dcnt;
  logic [D:0]                   r_sh;
  logic                         q_bit;

  // Rounding and saturation
  logic                         rnd;
  logic [A:0]                   q1, lim, qs;
  logic [P-1:0]                 res;
  logic signed [P-1:0]          pos_q, vel_q, acc_q;

  logic                         out_valid;

  // Step time register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      step_time <= cst_pkg::STEP_TIME_RESET;
    end else if (cfg.valid) begin
      step_time <= cfg.step_time;
    end
  end

  // Capture request with zero and limit clamps
  assign seg.ready = cmd.seg_ready;
  assign load      = seg.valid && cmd.seg_ready;
  always_comb begin
    n_in = seg.segment_steps;
    if (n_in == '0) begin
      n_in = cst_pkg::N_W'(1);
    end
    if (n_in > cst_pkg::N_W'(cst_pkg::STEP_LIMIT)) begin
      n_in = cst_pkg::N_W'(cst_pkg::STEP_LIMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      p0 <= seg.start_position;
      p1 <= seg.end_position;
      v0 <= seg.start_velocity;
      v1 <= seg.end_velocity;
      n  <= n_in;
      st <= (step_time == '0) ? cst_pkg::STEP_W'(1) : step_time;
    end
  end

  // Advance sample index
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (load) begin
      k <= '0;
    end else if (cmd.k_inc) begin
      k <= k + 1'b1;
    end
  end

  // Coefficient pipeline: first products, then sums and n cubed, then coefficients and divisors
  always_ff @(posedge clk) begin
    c1 <= 48'(v0) * $signed({32'h0, st});
    w1 <= 48'(v1) * $signed({32'h0, st});
    dd <= $signed({(33'(p1) - 33'(p0)), 16'h0});
    nn <= 12'(n) * 12'(n);
    sq <= 32'(st) * 32'(st);
    s2 <= (51'(c1) <<< 1) + 51'(w1);
    t2 <= 50'(c1) + 50'(w1);
    n3 <= 18'(nn) * 18'(n);
    c2 <= ((C'(dd) <<< 1) + C'(dd)) - C'(s2) * $signed(C'(n));
    c3 <= C'(t2) * $signed(C'(n)) - (C'(dd) <<< 1);
    d0 <= D'({n3, 16'h0});
    d1 <= D'(n3) * D'(st);
    d2 <= D'(n3) * D'(sq);
  end

  // Step products for the current sample index
  always_ff @(posedge clk) begin
    kk  <= 12'(k) * 12'(k);
    kkk <= 18'(kk) * 18'(k);
    kkn <= 18'(kk) * 18'(n);
    kn3 <= 24'(k) * 24'(n3);
    k2n <= 13'(13'(k) * 13'(n)) << 1;
    k3  <= 14'(kk) * 14'd3;
    k6  <= 9'(k) * 9'd6;
  end

  // Select coefficient and multiplier for the term
  always_comb begin
    case (cmd.term)
      cst_pkg::TERM_POS_P0: begin a_sel = C'($signed({p0, 16'h0})); m_sel = M'(n3);  end
      cst_pkg::TERM_POS_C1: begin a_sel = C'(c1);  m_sel = M'(kn3); end
      cst_pkg::TERM_POS_C2: begin a_sel = c2;      m_sel = M'(kkn); end
      cst_pkg::TERM_POS_C3: begin a_sel = c3;      m_sel = M'(kkk); end
      cst_pkg::TERM_VEL_C1: begin a_sel = C'(c1);  m_sel = M'(n3);  end
      cst_pkg::TERM_VEL_C2: begin a_sel = c2;      m_sel = M'(k2n); end
      cst_pkg::TERM_VEL_C3: begin a_sel = c3;      m_sel = M'(k3);  end
      cst_pkg::TERM_ACC_C2: begin a_sel = c2;      m_sel = M'({n, 17'h0}); end
      cst_pkg::TERM_ACC_C3: begin a_sel = c3;      m_sel = M'({k6, 16'h0}); end
      default:              begin a_sel = '0;      m_sel = '0; end
    endcase
  end

  // Bit-serial multiply-accumulate, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      m_reg <= '0;
    end else if (cmd.mac_start) begin
      a_reg <= A'(a_sel);
      m_reg <= m_sel;
      if (cmd.clear_acc) begin
        acc <= '0;
      end
    end else if (m_reg != '0) begin
      if (m_reg[0]) begin
        acc <= acc + a_reg;
      end
      a_reg <= a_reg <<< 1;
      m_reg <= m_reg >> 1;
    end
  end

  // Divisor for the field
  always_comb begin
    case (cmd.field)
      cst_pkg::FLD_POS: dv_sel = d0;
      cst_pkg::FLD_VEL: dv_sel = d1;
      default:          dv_sel = d2;
    endcase
  end

  // Restoring divider on the magnitude, one quotient bit per cycle
  assign r_sh  = {rem, mag[A-1]};
  assign q_bit = (r_sh >= {1'b0, dv});
  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.div_start) begin
      neg  <= acc[A-1];
      mag  <= acc[A-1] ? A'(-acc) : A'(acc);
      dv   <= dv_sel;
      rem  <= '0;
      dcnt <= cst_pkg::DCNT_W'(A);
    end else if (dcnt != '0) begin
      rem  <= q_bit ? D'(r_sh - {1'b0, dv}) : D'(r_sh);
      mag  <= {mag[A-2:0], q_bit};
      dcnt <= dcnt - 1'b1;
    end
  end

  // Round half away from zero, saturate, restore sign
  always_comb begin
    rnd = (rem >= (dv - rem));
    q1  = {1'b0, mag} + (A+1)'(rnd);
    lim = neg ? (A+1)'(64'h8000_0000) : (A+1)'(64'h7FFF_FFFF);
    qs  = (q1 > lim) ? lim : q1;
    res = neg ? P'(-qs[P-1:0]) : qs[P-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      case (cmd.field)
        cst_pkg::FLD_POS: pos_q <= $signed(res);
        cst_pkg::FLD_VEL: vel_q <= $signed(res);
        default:          acc_q <= $signed(res);
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (smp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      smp.position     <= pos_q;
      smp.velocity     <= vel_q;
      smp.acceleration <= acc_q;
      smp.sample_index <= k;
      smp.last         <= (k == n);
    end
  end

  assign smp.valid = out_valid;

  // Status to controller
  assign stat.seg_valid = seg.valid;
  assign stat.mac_busy  = (m_reg != '0);
  assign stat.div_busy  = (dcnt != '0);
  assign stat.out_free  = !out_valid || smp.ready;
  assign stat.last_k    = (k == n);

endmodule
